// ===== src/i2cmbe_pkg.sv =====
// Types and constants shared by the I2C master byte engine.
package i2cmbe_pkg;

	localparam int TX_W   = 8;
	localparam int HP_W   = 16;
	localparam int CMD_W  = 3;

	localparam logic [CMD_W-1:0] CMD_START = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WNACK = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

	localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd48;

	localparam logic [3:0] BITS_WITH_ACK = 4'd9;
	localparam logic [3:0] BITS_NO_ACK   = 4'd8;
	localparam logic [3:0] ACK_BIT       = 4'd8;

	typedef enum logic [3:0] {
		PH_DRIVE   = 4'd0,
		PH_STRETCH = 4'd1,
		PH_SAMPLE  = 4'd2,
		PH_TRAIL   = 4'd3,
		PH_EXTRA   = 4'd8,
		PH_FINISH  = 4'd9
	} phase_t;

	typedef struct packed {
		logic             cmd_valid;
		logic [CMD_W-1:0] command;
		logic [TX_W-1:0]  tx_byte;
		logic             send_ack;
		logic             sda_in;
		logic             scl_in;
	} item_t;

	typedef struct packed {
		logic            scl_drive_low;
		logic            sda_drive_low;
		logic            ready_res;
		logic            done_res;
		logic [TX_W-1:0] rx_byte;
		logic            ack_seen;
	} result_t;

endpackage

// ===== src/i2cmbe_in_reg.sv =====
// Input register stage of the I2C master byte engine.
module i2cmbe_in_reg
	import i2cmbe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  valid_s1,
	output item_t item_s1,
	input  logic  take
);

	logic vld_s1;

	assign in_ready = !vld_s1 || take;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== src/i2cmbe_core.sv =====
// Bus state update and result register of the I2C master byte engine.
module i2cmbe_core
	import i2cmbe_pkg::*;
#(
	parameter int WAIT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [HP_W-1:0] half_period,
	input  logic            valid_s1,
	input  item_t           item_s1,
	output logic            take,
	output logic            out_valid,
	input  logic            out_ready,
	output result_t         out_res
);

	localparam int EXT_W = (WAIT_WIDTH > HP_W) ? WAIT_WIDTH : HP_W;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_WACK  = 3'd3,
		MODE_WNACK = 3'd4,
		MODE_READ  = 3'd5
	} mode_t;

	mode_t                 mode_q, mode_n;
	logic [3:0]            phase_q, phase_n;
	logic [3:0]            bit_q, bit_n;
	logic [TX_W-1:0]       shift_q, shift_n;
	logic [WAIT_WIDTH-1:0] wait_q, wait_n;
	logic                  ackc_q, ackc_n;
	logic                  scl_q, scl_n;
	logic                  sda_q, sda_n;
	logic [TX_W-1:0]       rx_q, rx_n;
	logic                  ack_q, ack_n;
	logic                  done_d;
	logic                  rd;
	logic                  bv;
	logic [EXT_W-1:0]      hp_ext;
	logic [WAIT_WIDTH-1:0] load_val;
	logic [3:0]            bit_inc;
	logic [3:0]            bit_total;
	logic                  out_valid_q;
	result_t               res_q;

	assign take      = valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		hp_ext = EXT_W'(half_period);
		if (hp_ext > EXT_W'({WAIT_WIDTH{1'b1}})) begin
			load_val = '1;
		end else begin
			load_val = hp_ext[WAIT_WIDTH-1:0];
		end
	end

	always_comb begin
		mode_n  = mode_q;
		phase_n = phase_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		wait_n  = wait_q;
		ackc_n  = ackc_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		rx_n    = rx_q;
		ack_n   = ack_q;
		done_d  = 1'b0;
		rd      = (mode_q == MODE_WACK) ? (bit_q == ACK_BIT) :
		          (mode_q == MODE_READ) ? (bit_q < ACK_BIT) : 1'b0;
		bv      = (mode_q == MODE_READ) ? !ackc_q : shift_q[TX_W-1];
		bit_inc   = bit_q + 4'd1;
		bit_total = (mode_q == MODE_WNACK) ? BITS_NO_ACK : BITS_WITH_ACK;
		if (wait_q != '0) begin
			wait_n = wait_q - WAIT_WIDTH'(1);
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					if (item_s1.cmd_valid && item_s1.command <= CMD_READ) begin
						case (item_s1.command)
							CMD_START: mode_n = MODE_START;
							CMD_STOP:  mode_n = MODE_STOP;
							CMD_WACK:  mode_n = MODE_WACK;
							CMD_WNACK: mode_n = MODE_WNACK;
							default:   mode_n = MODE_READ;
						endcase
						phase_n = PH_DRIVE;
						bit_n   = '0;
						shift_n = (item_s1.command == CMD_READ) ? '0 : item_s1.tx_byte;
						ackc_n  = item_s1.send_ack;
					end
				end
				MODE_START, MODE_STOP: begin
					case (phase_q)
						4'd0: begin
							if (mode_q == MODE_START) begin
								scl_n = 1'b0;
								sda_n = 1'b0;
							end else begin
								sda_n = 1'b1;
							end
							wait_n  = load_val;
							phase_n = 4'd1;
						end
						4'd1: begin
							if (mode_q == MODE_START) sda_n = 1'b1;
							else scl_n = 1'b0;
							wait_n  = load_val;
							phase_n = 4'd2;
						end
						4'd2: begin
							if (mode_q == MODE_START) scl_n = 1'b1;
							else sda_n = 1'b0;
							wait_n  = load_val;
							phase_n = 4'd3;
						end
						default: begin
							done_d  = 1'b1;
							mode_n  = MODE_IDLE;
							phase_n = '0;
							bit_n   = '0;
						end
					endcase
				end
				MODE_WACK, MODE_WNACK, MODE_READ: begin
					case (phase_q)
						PH_DRIVE: begin
							sda_n   = rd ? 1'b0 : !bv;
							scl_n   = 1'b0;
							phase_n = PH_STRETCH;
						end
						PH_STRETCH: begin
							if (item_s1.scl_in) begin
								wait_n  = load_val;
								phase_n = PH_SAMPLE;
							end
						end
						PH_SAMPLE: begin
							scl_n  = 1'b1;
							wait_n = load_val;
							if (rd) begin
								if (mode_q == MODE_READ) begin
									shift_n = {shift_q[TX_W-2:0], item_s1.sda_in};
								end else begin
									ack_n = item_s1.sda_in;
								end
								bit_n = bit_inc;
								if (bit_inc >= bit_total) begin
									phase_n = (mode_q == MODE_READ) ? PH_EXTRA : PH_FINISH;
								end else begin
									phase_n = PH_DRIVE;
								end
							end else begin
								phase_n = PH_TRAIL;
							end
						end
						PH_TRAIL: begin
							if (bv) sda_n = 1'b1;
							wait_n = load_val;
							if (mode_q != MODE_READ) shift_n = {shift_q[TX_W-2:0], 1'b0};
							bit_n = bit_inc;
							if (bit_inc >= bit_total) begin
								phase_n = (mode_q == MODE_READ) ? PH_EXTRA : PH_FINISH;
							end else begin
								phase_n = PH_DRIVE;
							end
						end
						PH_EXTRA: begin
							wait_n  = load_val;
							phase_n = PH_FINISH;
						end
						default: begin
							if (mode_q == MODE_READ) rx_n = shift_q;
							done_d  = 1'b1;
							mode_n  = MODE_IDLE;
							phase_n = '0;
							bit_n   = '0;
						end
					endcase
				end
				default: begin
					mode_n  = MODE_IDLE;
					phase_n = '0;
					bit_n   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			phase_q     <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			wait_q      <= '0;
			ackc_q      <= 1'b0;
			scl_q       <= 1'b0;
			sda_q       <= 1'b0;
			rx_q        <= '0;
			ack_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q      <= mode_n;
				phase_q     <= phase_n;
				bit_q       <= bit_n;
				shift_q     <= shift_n;
				wait_q      <= wait_n;
				ackc_q      <= ackc_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				rx_q        <= rx_n;
				ack_q       <= ack_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.scl_drive_low <= scl_n;
			res_q.sda_drive_low <= sda_n;
			res_q.ready_res     <= (mode_n == MODE_IDLE);
			res_q.done_res      <= done_d;
			res_q.rx_byte       <= rx_n;
			res_q.ack_seen      <= ack_n;
		end
	end

endmodule

// ===== src/i2c_master_byte_engine_top.sv =====
// Top level of the I2C master byte engine.
//
//  channel | direction | handshake                      | payload
//  s_axis  | in        | s_axis_tvalid / s_axis_tready  | tick: pin samples and command
//  m_axis  | out       | m_axis_tvalid / m_axis_tready  | tick result: drives and status
//  cfg     | in        | cfg_valid / cfg_ready          | half_period_ticks
//
// One word in, one word out, one word per cycle sustained while the result is
// taken: an input register feeds the bus state update, which loads the result
// register in the same cycle.
// Reset clears the engine to idle with both lines released; half period is 48.
// A stalled result register holds the input register, which then drops tready.
module i2c_master_byte_engine_top
	import i2cmbe_pkg::*;
#(
	parameter int WAIT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// [7:0] tx_byte, [8] send_ack, [9] sda_in, [10] scl_in, [15:11] zero
	input  logic [15:0]     s_axis_tdata,
	// [0] cmd_valid, [3:1] command
	input  logic [3:0]      s_axis_tuser,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// [0] scl_drive_low, [1] sda_drive_low, [2] ready_res, [3] done_res,
	// [11:4] rx_byte, [12] ack_seen, [15:13] zero
	output logic [15:0]     m_axis_tdata,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [HP_W-1:0] cfg_data
);

	item_t           in_item;
	item_t           item_s1;
	logic            valid_s1;
	logic            take;
	result_t         res;
	logic [HP_W-1:0] half_period_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_valid) begin
			half_period_q <= cfg_data;
		end
	end

	always_comb begin
		in_item.cmd_valid = s_axis_tuser[0];
		in_item.command   = s_axis_tuser[3:1];
		in_item.tx_byte   = s_axis_tdata[7:0];
		in_item.send_ack  = s_axis_tdata[8];
		in_item.sda_in    = s_axis_tdata[9];
		in_item.scl_in    = s_axis_tdata[10];
	end

	i2cmbe_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	i2cmbe_core #(
		.WAIT_WIDTH (WAIT_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_period (half_period_q),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.take        (take),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res)
	);

	assign m_axis_tdata = {3'b000, res.ack_seen, res.rx_byte, res.done_res,
		res.ready_res, res.sda_drive_low, res.scl_drive_low};

endmodule
